### sv/assert_macros.svh
// assertion helpers used by the port checker file
// each macro expects signals named clk and rst_n in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OAIS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OAIS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/oais_pkg.sv
// ----------------------------------------------------------------------------
// oais_pkg
// Shared types and codes for the open-addressed integer set.
// ----------------------------------------------------------------------------
package oais_pkg;

    // command opcodes
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ABSENT   = 2'd0;
    localparam logic [1:0] ST_PRESENT  = 2'd1;
    localparam logic [1:0] ST_INSERTED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] key;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] element_count;
    } res_t;

endpackage

### sv/open_address_int_set.sv
// ----------------------------------------------------------------------------
// open_address_int_set
// Set of signed 32-bit keys in an open-addressed table with quadratic probing.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one find or insert per
//   transfer; res channel (res_valid/res_ready/res) returns one status and
//   the element count for each command, in order.
//   Commands are taken one at a time. Each passes through the home slot
//   unit (with reciprocal remainder steps when TABLE_SIZE is not a power
//   of two), a first slot read and the probe loop; the next command can
//   be taken as soon as the result is loaded. The probe loop reads one
//   slot per cycle from the key and occupancy RAMs. After reset the
//   occupancy RAM is swept clear, one slot per cycle; cmd_ready stays
//   low until that pass ends. The result register holds while res_ready
//   is low; one further command may be taken meanwhile and waits at its
//   final slot until the result register frees up.
//   Inserts beyond half the table, or after MAX_PROBES occupied slots, are
//   refused with the full status.
// ----------------------------------------------------------------------------
module open_address_int_set import oais_pkg::*; #(
    parameter int TABLE_SIZE = 64,
    parameter int MAX_PROBES = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int P_W   = $clog2(MAX_PROBES);
    localparam int LIMIT = TABLE_SIZE / 2;
    localparam int CNT_W = $clog2(LIMIT + 1);
    localparam logic [IDX_W:0] SIZE_X = (IDX_W + 1)'(TABLE_SIZE);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HOME  = 5'b00100,
        S_LOOK  = 5'b01000,
        S_PROBE = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             op_reg, op_next;
    logic [31:0]      key_reg, key_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [P_W-1:0]   p_reg, p_next;
    logic [IDX_W-1:0] sq_reg, sq_next;
    logic [IDX_W-1:0] dd_reg, dd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    res_t             res_reg, res_next;
    logic             res_valid_reg, res_valid_next;

    logic             home_done;
    logic [IDX_W-1:0] home_slot;
    logic             cmd_xfer;

    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    logic             key_we;
    logic             occ_we;
    logic             occ_wdata;
    logic [31:0]      key_rd;
    logic             occ_rd;

    logic             hit;
    logic             last;
    logic             finish;
    logic             can_out;
    logic             commit;
    logic             do_insert;
    logic             at_limit;
    logic [1:0]       status;
    logic [IDX_W-1:0] idx_step;

    // modular add of two slot-range values
    function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SIZE_X)
        begin
            s = s - SIZE_X;
        end
        return s[IDX_W-1:0];
    endfunction

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd_valid && cmd_ready;

    // home slot unit
    oais_home #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_home (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd_xfer),
        .key  (cmd.key),
        .done (home_done),
        .slot (home_slot)
    );

    // slot storage
    oais_ram #(
        .WIDTH(32),
        .DEPTH(TABLE_SIZE)
    ) u_keys (
        .clk  (clk),
        .we   (key_we),
        .waddr(waddr),
        .wdata(key_reg),
        .raddr(raddr),
        .rdata(key_rd)
    );

    oais_ram #(
        .WIDTH(1),
        .DEPTH(TABLE_SIZE)
    ) u_occ (
        .clk  (clk),
        .we   (occ_we),
        .waddr(waddr),
        .wdata(occ_wdata),
        .raddr(raddr),
        .rdata(occ_rd)
    );

    // probe decision on the slot just read
    always_comb
    begin
        hit      = occ_rd && (key_rd == key_reg);
        last     = (p_reg == P_W'(MAX_PROBES - 1));
        finish   = !occ_rd || hit || last;
        can_out  = !res_valid_reg || res_ready;
        at_limit = (count_reg >= CNT_W'(LIMIT));
        idx_step = mod_add(idx_reg, sq_reg);
        if (hit)
        begin
            status = ST_PRESENT;
        end
        else if (op_reg == OP_QUERY)
        begin
            status = ST_ABSENT;
        end
        else if (occ_rd || at_limit)
        begin
            status = ST_FULL;
        end
        else
        begin
            status = ST_INSERTED;
        end
        commit    = (state_reg == S_PROBE) && finish && can_out;
        do_insert = commit && (status == ST_INSERTED);
    end

    // memory ports
    always_comb
    begin
        if (state_reg == S_PROBE && !finish)
        begin
            raddr = idx_step;
        end
        else
        begin
            raddr = idx_reg;
        end
        if (state_reg == S_CLEAR)
        begin
            waddr     = clr_reg;
            occ_we    = 1'b1;
            occ_wdata = 1'b0;
        end
        else
        begin
            waddr     = idx_reg;
            occ_we    = do_insert;
            occ_wdata = 1'b1;
        end
        key_we = do_insert;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        p_next         = p_reg;
        sq_next        = sq_reg;
        dd_next        = dd_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    op_next    = cmd.opcode;
                    key_next   = cmd.key;
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                if (home_done)
                begin
                    idx_next   = home_slot;
                    p_next     = '0;
                    sq_next    = '0;
                    dd_next    = IDX_W'(1);
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (!finish)
                begin
                    // next index, then next square via odd-number increments
                    idx_next = idx_step;
                    p_next   = p_reg + P_W'(1);
                    sq_next  = mod_add(sq_reg, dd_reg);
                    dd_next  = mod_add(dd_reg, IDX_W'(2));
                end
                else if (can_out)
                begin
                    if (do_insert)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        res_next.element_count = 6'(count_reg + CNT_W'(1));
                    end
                    else
                    begin
                        res_next.element_count = 6'(count_reg);
                    end
                    res_next.status = status;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        idx_reg <= idx_next;
        p_reg   <= p_next;
        sq_reg  <= sq_next;
        dd_reg  <= dd_next;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### sv/oais_ram.sv
// ----------------------------------------------------------------------------
// oais_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module oais_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/oais_home.sv
// ----------------------------------------------------------------------------
// oais_home
// Home slot unit: non-negative remainder of a signed 32-bit key by the
// table size. A single mask step for power-of-two sizes; otherwise a
// reciprocal multiply and a correcting subtract. A sign correction step
// follows in both cases.
// ----------------------------------------------------------------------------
module oais_home import oais_pkg::*; #(
    parameter int TABLE_SIZE = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [31:0]                   key,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] slot
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    localparam longint WRAP = (64'd1 << 32) % TABLE_SIZE;
    localparam longint RECIP_L = (64'd1 << 32) / TABLE_SIZE;
    localparam logic [31:0] RECIP = 32'(RECIP_L);
    localparam logic [IDX_W-1:0] WRAP_MOD = IDX_W'(WRAP);
    localparam logic [IDX_W:0] SIZE_X = (IDX_W + 1)'(TABLE_SIZE);

    typedef enum logic [3:0] {
        H_IDLE = 4'b0001,
        H_MUL  = 4'b0010,
        H_SUB  = 4'b0100,
        H_FIX  = 4'b1000
    } home_state_t;

    home_state_t      state_reg, state_next;
    logic [31:0]      key_reg, key_next;
    logic             neg_reg, neg_next;
    logic [31:0]      quot_reg, quot_next;
    logic [IDX_W-1:0] rem_reg, rem_next;
    logic             done_reg, done_next;
    logic [IDX_W-1:0] slot_reg, slot_next;

    logic [63:0]      prod;
    logic [IDX_W:0]   qn;
    logic [IDX_W:0]   diff;
    logic [IDX_W:0]   wrapped;
    logic [IDX_W-1:0] fixed;

    // quotient estimate by reciprocal multiply, exact or low by one
    always_comb
    begin
        prod = {32'd0, key_reg} * {32'd0, RECIP};
    end

    // remainder from the estimate on the low bits, one subtract settles it
    always_comb
    begin
        qn   = quot_reg[IDX_W:0] * SIZE_X;
        diff = key_reg[IDX_W:0] - qn;
        if (diff >= SIZE_X)
        begin
            diff = diff - SIZE_X;
        end
    end

    // shift the remainder of the unsigned pattern to the signed value
    always_comb
    begin
        wrapped = {1'b0, rem_reg} + SIZE_X - {1'b0, WRAP_MOD};
        if (!neg_reg)
        begin
            fixed = rem_reg;
        end
        else if (rem_reg >= WRAP_MOD)
        begin
            fixed = rem_reg - WRAP_MOD;
        end
        else
        begin
            fixed = wrapped[IDX_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        neg_next   = neg_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;
        slot_next  = slot_reg;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    key_next = key;
                    neg_next = key[31];
                    if (IS_POW2)
                    begin
                        rem_next   = key[IDX_W-1:0];
                        state_next = H_FIX;
                    end
                    else
                    begin
                        state_next = H_MUL;
                    end
                end
            end
            H_MUL:
            begin
                quot_next  = prod[63:32];
                state_next = H_SUB;
            end
            H_SUB:
            begin
                rem_next   = diff[IDX_W-1:0];
                state_next = H_FIX;
            end
            H_FIX:
            begin
                slot_next  = fixed;
                done_next  = 1'b1;
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        slot_reg <= slot_next;
    end

    assign done = done_reg;
    assign slot = slot_reg;

endmodule

### sv/oais_checker.sv
// ----------------------------------------------------------------------------
// oais_port_checks
// Port-level checks for the open-addressed integer set, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oais_port_checks import oais_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input cmd_t cmd,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    logic [5:0] last_cnt_reg;
    logic [1:0] pending_reg;
    logic       cmd_xfer;
    logic       res_xfer;
    logic       res_stall;
    logic       ins_xfer;
    logic       keep_xfer;
    logic [5:0] cnt_inc;

    assign cmd_xfer  = cmd_valid && cmd_ready;
    assign res_xfer  = res_valid && res_ready;
    assign res_stall = res_valid && !res_ready;
    assign ins_xfer  = res_xfer && (res.status == ST_INSERTED);
    assign keep_xfer = res_xfer && (res.status != ST_INSERTED);
    assign cnt_inc   = last_cnt_reg + 6'd1;

    // track last delivered count and commands in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cnt_reg <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            if (res_xfer)
            begin
                last_cnt_reg <= res.element_count;
            end
            pending_reg <= pending_reg + {1'b0, cmd_xfer} - {1'b0, res_xfer};
        end
    end

    `OAIS_ASSERT_NXT(a_res_hold, res_stall, res_valid && $stable(res), "result moved in stall")
    `OAIS_ASSERT_NXT(a_one_cmd, cmd_xfer, !cmd_ready, "command taken in back-to-back cycles")
    `OAIS_ASSERT_IMP(a_cnt_ins, ins_xfer, res.element_count == cnt_inc, "count did not grow")
    `OAIS_ASSERT_IMP(a_cnt_same, keep_xfer, res.element_count == last_cnt_reg, "count moved")
    `OAIS_ASSERT_IMP(a_no_phantom, res_valid, pending_reg != 2'd0, "result without a command")

endmodule

bind open_address_int_set oais_port_checks u_oais_checker (.*);

### verif/oais_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oais_checker
// Watches the command and result channels of the integer set, keeps a shadow
// copy of the hash table, predicts status and element count for every
// command transfer and compares each result transfer against the oldest one.
// ----------------------------------------------------------------------------
module oais_checker import oais_pkg::*; #(
    parameter int TABLE_SIZE = 64,
    parameter int MAX_PROBES = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_ready,
    input  cmd_t cmd,
    input  logic res_valid,
    input  logic res_ready,
    input  res_t res,
    output int   err_count,
    output int   outstanding,
    output int   checked,
    output int   keys_held
);

    typedef struct {
        cmd_t c;
        res_t r;
    } awaited_t;

    // shadow table
    logic [31:0] shadow_key [TABLE_SIZE];
    bit          shadow_used [TABLE_SIZE];
    int          shadow_count;

    awaited_t awaited_res[$];

    task automatic report(string msg);
        if (err_count < 100)
            $display("[%0t] MISMATCH %s", $time, msg);
        err_count++;
    endtask

    // probe the shadow table, apply an insert, return the predicted result
    function automatic res_t probe_and_apply(cmd_t c);
        longint idx;
        int     outcome;
        res_t   r;
        idx = longint'(c.key) % TABLE_SIZE;
        if (idx < 0)
            idx += TABLE_SIZE;
        // 0: empty slot reached, 1: key matched, 2: probe limit ran out
        outcome = 2;
        for (int p = 0; p < MAX_PROBES; p++)
        begin
            if (!shadow_used[idx])
            begin
                outcome = 0;
                break;
            end
            if (shadow_key[idx] == c.key)
            begin
                outcome = 1;
                break;
            end
            idx = (idx + longint'(p) * p) % TABLE_SIZE;
        end
        if (c.opcode == OP_QUERY)
            r.status = (outcome == 1) ? ST_PRESENT : ST_ABSENT;
        else if (outcome == 1)
            r.status = ST_PRESENT;
        else if (outcome == 2)
            r.status = ST_FULL;
        else if (2 * (shadow_count + 1) > TABLE_SIZE)
            r.status = ST_FULL;
        else
        begin
            shadow_key[idx]  = c.key;
            shadow_used[idx] = 1'b1;
            shadow_count++;
            r.status = ST_INSERTED;
        end
        r.element_count = 6'(shadow_count);
        return r;
    endfunction

    // result check and command prediction
    always @(posedge clk)
    begin
        awaited_t e;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (awaited_res.size() == 0)
                    report($sformatf("result with nothing pending: status=%0d count=%0d",
                                     res.status, res.element_count));
                else
                begin
                    e = awaited_res.pop_front();
                    checked++;
                    if (res.status !== e.r.status)
                        report($sformatf("status op=%0b key=%0d: got %0d, expected %0d",
                                         e.c.opcode, e.c.key, res.status, e.r.status));
                    if (res.element_count !== e.r.element_count)
                        report($sformatf("count op=%0b key=%0d: got %0d, expected %0d",
                                         e.c.opcode, e.c.key, res.element_count,
                                         e.r.element_count));
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                e.c = cmd;
                e.r = probe_and_apply(cmd);
                awaited_res.push_back(e);
            end
            outstanding = awaited_res.size();
            keys_held   = shadow_count;
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the open-addressed integer set: directed finds and
// inserts on colliding and extreme keys, then random commands over several
// sender-gap and receiver-stall phases with one long result hold-off.
// ----------------------------------------------------------------------------
module tb;
    import oais_pkg::*;

    localparam int TABLE_SIZE   = 64;
    localparam int MAX_PROBES   = 64;
    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    int err_count;
    int outstanding;
    int checked;
    int keys_held;

    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    int held      = 0;
    int cycles    = 0;
    int n_sent    = 0;
    int n_inserts = 0;

    logic [31:0] inserted_keys[$];

    always #1 clk = ~clk;

    open_address_int_set #(
        .TABLE_SIZE (TABLE_SIZE),
        .MAX_PROBES (MAX_PROBES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    oais_checker #(
        .TABLE_SIZE (TABLE_SIZE),
        .MAX_PROBES (MAX_PROBES)
    ) watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .err_count   (err_count),
        .outstanding (outstanding),
        .checked     (checked),
        .keys_held   (keys_held)
    );

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && held < HOLD_CYCLES)
        begin
            res_ready <= 1'b0;
            held      <= held + 1;
        end
        else
            res_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending", cycles, outstanding);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one command transfer; valid stays high on return unless gaps follow
    task automatic issue(input logic op, input logic [31:0] key);
        cmd_t c;
        c.opcode = op;
        c.key    = key;
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        n_sent++;
        if (op == OP_INSERT)
        begin
            n_inserts++;
            inserted_keys.push_back(key);
        end
    endtask

    // key mix: earlier inserts, home-slot collisions, anything, extremes
    function automatic logic [31:0] pick_key();
        int          sel;
        logic [31:0] home;
        sel = $urandom_range(99);
        if (sel < 30 && inserted_keys.size() > 0)
            return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        if (sel < 65)
        begin
            case ($urandom_range(3))
                0: home = 32'd0;
                1: home = 32'd1;
                2: home = 32'd5;
                default: home = 32'd63;
            endcase
            return ($urandom() & ~32'h3f) | home;
        end
        if (sel < 90)
            return $urandom();
        case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return 32'h8000_0001;
            default: return 32'h7fff_fffe;
        endcase
    endfunction

    task automatic random_phase(input int gap, input int stall);
        logic op;
        idle_pct  = gap;
        stall_pct <= stall;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            op = ($urandom_range(99) < 12) ? OP_INSERT : OP_QUERY;
            issue(op, pick_key());
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, extreme keys
        issue(OP_QUERY,  32'h0000_0000);
        issue(OP_QUERY,  32'h8000_0000);
        issue(OP_QUERY,  32'h7fff_ffff);
        issue(OP_QUERY,  32'hffff_ffff);
        // collisions on home slots 0 and 63, negative keys wrap upward
        issue(OP_INSERT, 32'h0000_0000);
        issue(OP_INSERT, 32'h8000_0000);
        issue(OP_INSERT, 32'h7fff_ffff);
        issue(OP_INSERT, 32'hffff_ffff);
        issue(OP_INSERT, 32'hffff_ffc0);
        issue(OP_INSERT, 32'h0000_0040);
        // insert of keys already held
        issue(OP_INSERT, 32'h0000_0000);
        issue(OP_INSERT, 32'h7fff_ffff);
        // finds that walk the probe chain
        issue(OP_QUERY,  32'h8000_0000);
        issue(OP_QUERY,  32'h0000_0080);
        issue(OP_QUERY,  32'hffff_ffff);
        issue(OP_QUERY,  32'h0000_0001);
        issue(OP_INSERT, 32'h0000_0001);
        issue(OP_QUERY,  32'h0000_0001);

        // long result hold-off while commands keep coming
        hold_req <= 1'b1;
        random_phase(0, 0);
        random_phase(69, 0);
        random_phase(0, 69);
        random_phase(28, 28);

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands (%0d inserts) sent, %0d results checked, %0d keys held at end",
                 n_sent, n_inserts, checked, keys_held);
        $display("phases: back-to-back, sender gaps, receiver stalls, both, %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
